### rtl/glow_plug_current_regulator_macros.svh
// ----------------------------------------------------------------------------
// Glow plug current regulator assertion macros
// Shared concurrent assertion forms, sampled on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef GLOW_PLUG_CURRENT_REGULATOR_MACROS_SVH
`define GLOW_PLUG_CURRENT_REGULATOR_MACROS_SVH

// same-cycle implication
`define GPCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpcr assertion failed");

// next-cycle implication
`define GPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpcr assertion failed");

`endif

### rtl/gpcr_pkg.sv
// ----------------------------------------------------------------------------
// gpcr_pkg
// Types, register indexes and reset values shared by the regulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gpcr_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PWM_PERIOD      = 3'd0,
        CFG_STICK_OFF_THR   = 3'd1,
        CFG_THROTTLE_INV    = 3'd2,
        CFG_OVERCURRENT_LIM = 3'd3,
        CFG_STARTUP_TARGET  = 3'd4,
        CFG_RUNNING_TARGET  = 3'd5,
        CFG_BAND_HYST       = 3'd6,
        CFG_STARTUP_SECONDS = 3'd7
    } cfg_index_t;

    localparam logic [15:0] RST_PWM_PERIOD      = 16'd1000;
    localparam logic [15:0] RST_STICK_OFF_THR   = 16'd1500;
    localparam logic        RST_THROTTLE_INV    = 1'b0;
    localparam logic [11:0] RST_OVERCURRENT_LIM = 12'd1800;
    localparam logic [11:0] RST_STARTUP_TARGET  = 12'd500;
    localparam logic [11:0] RST_RUNNING_TARGET  = 12'd350;
    localparam logic [11:0] RST_BAND_HYST       = 12'd20;
    localparam logic [7:0]  RST_STARTUP_SECONDS = 8'd120;

    localparam logic [31:0] MS_PER_SECOND = 32'd1000;

    typedef struct packed {
        logic [15:0] pwm_period;
        logic [15:0] stick_off_threshold;
        logic        stick_reverse;
        logic [11:0] overcurrent_limit;
        logic [11:0] startup_target;
        logic [11:0] running_target;
        logic [11:0] band_hysteresis;
        logic [7:0]  startup_seconds;
    } cfg_t;

    typedef struct packed {
        logic        pulse_valid;
        logic [15:0] stick_width;
        logic [11:0] current_sample;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [15:0] duty;
        logic        timer_enabled;
        logic        regulating;
        logic        running_mode;
        logic        over_current;
    } out_word_t;

endpackage

`default_nettype wire

### rtl/gpcr_cfg.sv
// ----------------------------------------------------------------------------
// gpcr_cfg
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcr_cfg
    import gpcr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PWM_PERIOD:      cfg_next.pwm_period          = cfg_data;
                CFG_STICK_OFF_THR:   cfg_next.stick_off_threshold = cfg_data;
                CFG_THROTTLE_INV:    cfg_next.stick_reverse       = cfg_data[0];
                CFG_OVERCURRENT_LIM: cfg_next.overcurrent_limit   = cfg_data[11:0];
                CFG_STARTUP_TARGET:  cfg_next.startup_target      = cfg_data[11:0];
                CFG_RUNNING_TARGET:  cfg_next.running_target      = cfg_data[11:0];
                CFG_BAND_HYST:       cfg_next.band_hysteresis     = cfg_data[11:0];
                CFG_STARTUP_SECONDS: cfg_next.startup_seconds     = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_period          <= RST_PWM_PERIOD;
            cfg_reg.stick_off_threshold <= RST_STICK_OFF_THR;
            cfg_reg.stick_reverse       <= RST_THROTTLE_INV;
            cfg_reg.overcurrent_limit   <= RST_OVERCURRENT_LIM;
            cfg_reg.startup_target      <= RST_STARTUP_TARGET;
            cfg_reg.running_target      <= RST_RUNNING_TARGET;
            cfg_reg.band_hysteresis     <= RST_BAND_HYST;
            cfg_reg.startup_seconds     <= RST_STARTUP_SECONDS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gpcr_core.sv
// ----------------------------------------------------------------------------
// gpcr_core
// Control pass logic and regulator state: mode timing, pulse check, duty step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "glow_plug_current_regulator_macros.svh"

module gpcr_core
    import gpcr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire cfg_t     cfg,
    input  wire in_word_t word,
    output out_word_t     result
);

    logic        regulate_reg;
    logic        running_reg;
    logic [7:0]  seconds_reg;
    logic [31:0] mark_reg;
    logic [15:0] duty_reg;
    logic        timer_reg;

    logic        regulate_next;
    logic        running_next;
    logic [7:0]  seconds_next;
    logic [31:0] mark_next;
    logic [15:0] duty_next;
    logic        timer_next;
    logic        over_next;

    logic [31:0] elapsed;
    logic        tick;
    logic [7:0]  seconds_inc;
    logic        enter_running;
    logic        stick_off;
    logic [11:0] target;
    logic [12:0] sample_plus_hyst;
    logic [12:0] target_plus_hyst;
    logic        below_band;
    logic        above_band;

    assign elapsed       = word.now_ms - mark_reg;
    assign tick          = !running_reg && (elapsed >= MS_PER_SECOND);
    assign seconds_inc   = seconds_reg + 8'd1;
    assign enter_running = tick && (seconds_inc >= cfg.startup_seconds);

    assign stick_off = cfg.stick_reverse ? (word.stick_width <= cfg.stick_off_threshold)
                                         : (word.stick_width >= cfg.stick_off_threshold);

    assign target           = (running_reg || enter_running) ? cfg.running_target
                                                             : cfg.startup_target;
    assign sample_plus_hyst = {1'b0, word.current_sample} + {1'b0, cfg.band_hysteresis};
    assign target_plus_hyst = {1'b0, target} + {1'b0, cfg.band_hysteresis};
    assign below_band       = sample_plus_hyst < {1'b0, target};
    assign above_band       = {1'b0, word.current_sample} > target_plus_hyst;

    always_comb
    begin
        seconds_next  = seconds_reg;
        mark_next     = mark_reg;
        running_next  = running_reg;
        regulate_next = regulate_reg;
        duty_next     = duty_reg;
        timer_next    = timer_reg;
        over_next     = 1'b0;

        if (tick)
        begin
            mark_next    = word.now_ms;
            seconds_next = seconds_inc;
            if (enter_running)
            begin
                running_next = 1'b1;
            end
        end

        if (!word.pulse_valid)
        begin
            duty_next     = '0;
            timer_next    = 1'b0;
            regulate_next = 1'b0;
        end
        else if (!regulate_reg)
        begin
            if (!stick_off)
            begin
                timer_next    = 1'b1;
                regulate_next = 1'b1;
            end
        end
        else if (stick_off)
        begin
            duty_next     = '0;
            regulate_next = 1'b0;
        end
        else if (word.current_sample >= cfg.overcurrent_limit)
        begin
            over_next = 1'b1;
            if (duty_reg != '0)
            begin
                duty_next = duty_reg - 16'd1;
            end
        end
        else if (below_band)
        begin
            if (duty_reg < cfg.pwm_period)
            begin
                duty_next = duty_reg + 16'd1;
            end
        end
        else if (above_band)
        begin
            if (duty_reg != '0)
            begin
                duty_next = duty_reg - 16'd1;
            end
        end
    end

    assign result.duty          = duty_next;
    assign result.timer_enabled = timer_next;
    assign result.regulating    = regulate_next;
    assign result.running_mode  = running_next;
    assign result.over_current  = over_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regulate_reg <= 1'b0;
            running_reg  <= 1'b0;
            seconds_reg  <= '0;
            mark_reg     <= '0;
            duty_reg     <= '0;
            timer_reg    <= 1'b0;
        end
        else if (step)
        begin
            regulate_reg <= regulate_next;
            running_reg  <= running_next;
            seconds_reg  <= seconds_next;
            mark_reg     <= mark_next;
            duty_reg     <= duty_next;
            timer_reg    <= timer_next;
        end
    end

    `GPCR_ASSERT_SAME(a_timer_off_duty_zero, clk, rst_n, !timer_reg, duty_reg == '0)
    `GPCR_ASSERT_SAME(a_regulating_timer_on, clk, rst_n, regulate_reg, timer_reg)
    `GPCR_ASSERT_NEXT(a_running_sticky, clk, rst_n, running_reg, running_reg)
    `GPCR_ASSERT_SAME(a_over_only_regulating, clk, rst_n, over_next, regulate_reg && regulate_next)

endmodule

`default_nettype wire

### rtl/glow_plug_current_regulator.sv
// ----------------------------------------------------------------------------
// glow_plug_current_regulator
// Glow plug PWM duty regulator: one control pass per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one control pass per word:
//   pulse validity, throttle width, current sample and millisecond time.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   duty, timer enable, regulating state, running mode and overcurrent flag.
//   Configuration channel (cfg_valid/cfg_ready) writes one register per word;
//   it is always ready; the user must write it only while the block is idle
//   (not enforced by the block). Words pass the input register, then the
//   result register. Throughput: one word per cycle while out_ready holds,
//   set by the single compare and increment pass between the two registers.
//   Reset loads the default configuration, startup mode, waiting state,
//   duty zero and timer off; both pipeline stages come up empty.
//   A stalled receiver holds the result register; the input register fills,
//   then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module glow_plug_current_regulator
    import gpcr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   pulse_valid,
    input  wire logic [15:0]            stick_width,
    input  wire logic [11:0]            current_sample,
    input  wire logic [31:0]            now_ms,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [15:0]                 duty,
    output logic                        timer_enabled,
    output logic                        regulating,
    output logic                        running_mode,
    output logic                        over_current,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    in_word_t  in_word_reg;
    logic      in_valid_reg;
    out_word_t out_word_reg;
    logic      out_valid_reg;
    out_word_t pass_result;
    logic      advance;
    logic      step;

    gpcr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    gpcr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .word   (in_word_reg),
        .result (pass_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg.pulse_valid    <= pulse_valid;
            in_word_reg.stick_width    <= stick_width;
            in_word_reg.current_sample <= current_sample;
            in_word_reg.now_ms         <= now_ms;
        end
        if (step)
        begin
            out_word_reg <= pass_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign duty          = out_word_reg.duty;
    assign timer_enabled = out_word_reg.timer_enabled;
    assign regulating    = out_word_reg.regulating;
    assign running_mode  = out_word_reg.running_mode;
    assign over_current  = out_word_reg.over_current;

endmodule

`default_nettype wire
